/* src/rpn_integer_stack_evaluator_defines.svh */
// ------------------------------------------------------------------------
// RPN stack evaluator assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet in reset.
// ------------------------------------------------------------------------
`ifndef RPN_INTEGER_STACK_EVALUATOR_DEFINES_SVH
`define RPN_INTEGER_STACK_EVALUATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define RPN_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RPN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/rpn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// RPN evaluator package
// Types, command and status codes, and sizes shared by the evaluator.
// ------------------------------------------------------------------------
package rpn_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	localparam int DATA_W     = 32;
	localparam int DIV_STEPS  = DATA_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	// token commands
	localparam logic [2:0] CMD_PUSH = 3'd0;
	localparam logic [2:0] CMD_ADD  = 3'd1;
	localparam logic [2:0] CMD_SUB  = 3'd2;
	localparam logic [2:0] CMD_MUL  = 3'd3;
	localparam logic [2:0] CMD_DIV  = 3'd4;
	localparam logic [2:0] CMD_END  = 3'd5;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_UNDER   = 3'd2;
	localparam logic [2:0] ST_OVER    = 3'd3;
	localparam logic [2:0] ST_DIVZERO = 3'd4;

	typedef struct packed {
		logic [2:0]               command;
		logic signed [DATA_W-1:0] operand_value;
	} tok_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic [2:0]               status;
	} res_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIVW,
		S_WB
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       push;
		logic       flag;
		logic [2:0] flag_code;
		logic       op_start;
		logic [2:0] op;
		logic       alu_load;
		logic       div_start;
		logic       div_load;
		logic       wb;
		logic       finish;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic full;
		logic lt2;
		logic b_zero;
		logic div_done;
		logic out_blocked;
	} dp_stat_t;

endpackage
`default_nettype wire

/* src/rpn_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// RPN signed divider
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle,
// truncating toward zero; quotient sign fixed on output.
// ------------------------------------------------------------------------
module rpn_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [rpn_pkg::DATA_W-1:0] dividend,
	input  wire logic [rpn_pkg::DATA_W-1:0] divisor,
	output logic                           done,
	output logic [rpn_pkg::DATA_W-1:0]      quotient
);
	import rpn_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W-1:0]    dvs_q;

	logic [DATA_W:0]      shifted;
	logic [DATA_W:0]      diff;
	logic [DATA_W-1:0]    dvd_mag;
	logic [DATA_W-1:0]    dvs_mag;

	assign dvd_mag = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
	assign dvs_mag = divisor[DATA_W-1]  ? (~divisor + DATA_W'(1))  : divisor;
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			rem_q <= '0;
			quo_q <= dvd_mag;
			dvs_q <= dvs_mag;
		end else if (busy_q) begin
			if (!diff[DATA_W]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + DATA_W'(1)) : quo_q;

endmodule
`default_nettype wire

/* src/rpn_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// RPN datapath
// Operand stack memory, top-of-stack copy, count, sticky status, ALU,
// divider and the result register.
// ------------------------------------------------------------------------
module rpn_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rpn_pkg::tok_item_t tok,
	input  wire logic               res_stall,
	input  wire rpn_pkg::dp_cmd_t   cmd,
	output rpn_pkg::dp_stat_t       stat,
	output logic                    res_valid,
	output rpn_pkg::res_item_t      res
);
	import rpn_pkg::*;

	logic [DATA_W-1:0] mem_q [STACK_DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic [DATA_W-1:0] top_q;
	logic [DATA_W-1:0] res_q;
	logic [CNT_W-1:0]  count_q;
	logic [2:0]        err_q;
	logic              out_valid_q;
	res_item_t         out_item_q;

	logic [CNT_W-1:0]  count_m2;
	logic [ADDR_W-1:0] addr_m2;
	logic [ADDR_W-1:0] addr_top;
	logic [DATA_W-1:0] alu;
	logic [DATA_W-1:0] quotient;
	logic              div_done;
	logic              cnt_zero;

	assign count_m2 = count_q - CNT_W'(2);
	assign addr_m2  = count_m2[ADDR_W-1:0];
	assign addr_top = count_q[ADDR_W-1:0];
	assign cnt_zero = (count_q == '0);

	// a = entry below top, b = top
	always_comb begin
		unique case (cmd.op)
			CMD_ADD: alu = rd_data_q + top_q;
			CMD_SUB: alu = rd_data_q - top_q;
			CMD_MUL: alu = rd_data_q * top_q;
			default: alu = '0;
		endcase
	end

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rd_data_q),
		.divisor  (top_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// stack memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_q[addr_top] <= tok.operand_value;
		end else if (cmd.wb) begin
			mem_q[addr_m2] <= res_q;
		end
		if (cmd.op_start) begin
			rd_data_q <= mem_q[addr_m2];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q <= tok.operand_value;
		end else if (cmd.wb) begin
			top_q <= res_q;
		end
		if (cmd.alu_load) begin
			res_q <= alu;
		end else if (cmd.div_load) begin
			res_q <= quotient;
		end
		if (cmd.finish) begin
			if (err_q != ST_OK) begin
				out_item_q.result_value <= '0;
				out_item_q.status       <= err_q;
			end else if (cnt_zero) begin
				out_item_q.result_value <= '0;
				out_item_q.status       <= ST_EMPTY;
			end else begin
				out_item_q.result_value <= top_q;
				out_item_q.status       <= ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.wb) begin
				count_q <= count_q - CNT_W'(1);
			end else if (cmd.finish) begin
				count_q <= '0;
			end
			if (cmd.finish) begin
				err_q <= ST_OK;
			end else if (cmd.flag && err_q == ST_OK) begin
				err_q <= cmd.flag_code;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.full        = (count_q == CNT_W'(STACK_DEPTH));
	assign stat.lt2         = (count_q < CNT_W'(2));
	assign stat.b_zero      = (top_q == '0);
	assign stat.div_done    = div_done;
	assign stat.out_blocked = out_valid_q && res_stall;

	assign res_valid = out_valid_q;
	assign res       = out_item_q;

endmodule
`default_nettype wire

/* src/rpn_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// RPN controller
// Token decode and operator sequencing: fetch, execute or divide, write back.
// ------------------------------------------------------------------------
module rpn_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               tok_valid,
	input  wire rpn_pkg::tok_item_t tok,
	input  wire rpn_pkg::dp_stat_t  stat,
	output logic                    tok_stall,
	output rpn_pkg::dp_cmd_t        cmd
);
	import rpn_pkg::*;

	state_t     state_q;
	state_t     state_d;
	logic [2:0] op_q;
	logic       accept;

	// any token waits while an operator is in progress; an end token also waits while a held result is stalled
	assign tok_stall = (state_q != S_IDLE) || ((tok.command == CMD_END) && stat.out_blocked);
	assign accept    = tok_valid && !tok_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= CMD_ADD;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= tok.command;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !stat.lt2 && tok.command >= CMD_ADD && tok.command <= CMD_DIV) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (op_q == CMD_DIV) begin
					state_d = stat.b_zero ? S_IDLE : S_DIVW;
				end else begin
					state_d = S_WB;
				end
			end
			S_DIVW: begin
				if (stat.div_done) begin
					state_d = S_WB;
				end
			end
			S_WB:    state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd    = '0;
		cmd.op = op_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (tok.command) inside
						CMD_PUSH: begin
							if (stat.full) begin
								cmd.flag      = 1'b1;
								cmd.flag_code = ST_OVER;
							end else begin
								cmd.push = 1'b1;
							end
						end
						CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
							if (stat.lt2) begin
								cmd.flag      = 1'b1;
								cmd.flag_code = ST_UNDER;
							end else begin
								cmd.op_start = 1'b1;
							end
						end
						CMD_END:  cmd.finish = 1'b1;
						default:  cmd.finish = 1'b0;
					endcase
				end
			end
			S_EXEC: begin
				if (op_q == CMD_DIV) begin
					if (stat.b_zero) begin
						cmd.flag      = 1'b1;
						cmd.flag_code = ST_DIVZERO;
					end else begin
						cmd.div_start = 1'b1;
					end
				end else begin
					cmd.alu_load = 1'b1;
				end
			end
			S_DIVW:  cmd.div_load = stat.div_done;
			S_WB:    cmd.wb = 1'b1;
			default: cmd.wb = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

/* src/rpn_integer_stack_evaluator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// RPN integer stack evaluator
// Postfix integer expression evaluator on a 16-entry operand stack.
// ------------------------------------------------------------------------
// Takes one postfix token per item on the tok channel and returns one item
// on the res channel for each end token. Push, end and unused codes leave
// the sequencer idle, so a new item can follow on the next clock. Add,
// subtract and multiply step through accept with stack read, execute and
// write back. Divide steps through accept with stack read, execute, a wait
// on the radix-2 divider, which retires one quotient bit per cycle, and write
// back. A divide by zero returns to idle without starting the divider.
// The result sits in an output register, so tokens keep flowing while it
// waits; only an end token is held off while an earlier result has not
// been taken. Stack memory needs no clearing after reset.
module rpn_integer_stack_evaluator (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// token channel
	input  wire logic               tok_valid,
	output logic                    tok_stall,
	input  wire rpn_pkg::tok_item_t tok,
	// result channel
	output logic                    res_valid,
	input  wire logic               res_stall,
	output rpn_pkg::res_item_t      res
);
	import rpn_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: decodes tokens, steps operators through the datapath
	rpn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok),
		.stat      (stat),
		.tok_stall (tok_stall),
		.cmd       (cmd)
	);

	// stack, ALU, divider, sticky status and result register
	rpn_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok),
		.res_stall (res_stall),
		.cmd       (cmd),
		.stat      (stat),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule
`default_nettype wire

/* src/rpn_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// RPN evaluator port checker
// Watches the top-level ports for result ordering and content rules.
// ------------------------------------------------------------------------
`include "rpn_integer_stack_evaluator_defines.svh"

module rpn_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               tok_valid,
	input wire logic               tok_stall,
	input wire rpn_pkg::tok_item_t tok,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire rpn_pkg::res_item_t res
);
	import rpn_pkg::*;

	// a waiting result must stay put
	`RPN_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")

	// an accepted end token always yields a result next cycle
	`RPN_ASSERT_NEXT(a_end_result, tok_valid && !tok_stall && tok.command == CMD_END, res_valid, "end token gave no result")

	// error results carry a zero value
	`RPN_ASSERT_SAME(a_err_zero, res_valid && res.status != ST_OK, res.result_value == '0, "error result with nonzero value")

	// status stays within the defined codes
	`RPN_ASSERT_SAME(a_status_rng, res_valid, res.status <= ST_DIVZERO, "undefined status code")

endmodule

bind rpn_integer_stack_evaluator rpn_chk u_chk (.*);
`default_nettype wire
